@@ src/huffman_code_builder_top_assert.svh @@
// Assertion macros for the Huffman code builder.
// No dependencies; taken in by the top level with an include.
`ifndef HUFFMAN_CODE_BUILDER_TOP_ASSERT_SVH
`define HUFFMAN_CODE_BUILDER_TOP_ASSERT_SVH

// condition holds at every edge out of reset
`define HFCB_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("hfcb: invariant violated");

// condition implies a consequence on the next edge
`define HFCB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hfcb: sequence violated");

`endif

@@ src/hfcb_pkg.sv @@
// Shared types for the Huffman code builder.
// No dependencies.
package hfcb_pkg;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_POP,
      ST_MERGE,
      ST_FETCH,
      ST_VISIT,
      ST_STACK,
      ST_RESUME
   } hfcb_state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_POP2,
      CELL_CLEAR
   } hfcb_cell_op_type;

   localparam int SYMBOL_BITS = 8;
   localparam int FREQ_PORT_BITS = 16;
   localparam int CODE_BITS = 15;
   localparam int LEN_BITS = 4;

endpackage

@@ src/hfcb_req_if.sv @@
// Word channels for the Huffman code builder: request and response.
// Depends on nothing; widths are the fixed field widths.
interface hfcb_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] frequency;
   logic [7:0]  symbol;
   logic        final_item;

   modport source(output valid, frequency, symbol, final_item, input ready);
   modport sink(input valid, frequency, symbol, final_item, output ready);
endinterface

interface hfcb_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  leaf_symbol;
   logic [14:0] code_bits;
   logic [3:0]  code_length;
   logic        last_code;

   modport source(output valid, leaf_symbol, code_bits, code_length, last_code, input ready);
   modport sink(input valid, leaf_symbol, code_bits, code_length, last_code, output ready);
endinterface

@@ src/hfcb_cell.sv @@
// One slot of the sorted node list: weight, node index, valid.
// Depends on hfcb_pkg.
module hfcb_cell #(
   parameter int WW = 20,
   parameter int IW = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  hfcb_pkg::hfcb_cell_op_type op,
   input  logic [WW-1:0]              new_weight,
   input  logic [IW-1:0]              new_index,
   input  logic                       prev_ge,
   input  logic                       prev_valid,
   input  logic [WW-1:0]              prev_weight,
   input  logic [IW-1:0]              prev_index,
   input  logic                       far_valid,
   input  logic [WW-1:0]              far_weight,
   input  logic [IW-1:0]              far_index,
   output logic                       ge,
   output logic                       valid,
   output logic [WW-1:0]              weight,
   output logic [IW-1:0]              index
);
   import hfcb_pkg::*;

   logic          valid_ff, valid_in;
   logic [WW-1:0] weight_ff, weight_in;
   logic [IW-1:0] index_ff, index_in;

   // empty slot counts as past the end
   assign ge = !valid_ff || (weight_ff >= new_weight);

   always_comb begin
      valid_in  = valid_ff;
      weight_in = weight_ff;
      index_in  = index_ff;
      unique case (op)
         CELL_INSERT: begin
            if (prev_ge) begin
               valid_in  = prev_valid;
               weight_in = prev_weight;
               index_in  = prev_index;
            end else if (ge) begin
               valid_in  = 1'b1;
               weight_in = new_weight;
               index_in  = new_index;
            end
         end
         CELL_POP2: begin
            valid_in  = far_valid;
            weight_in = far_weight;
            index_in  = far_index;
         end
         CELL_CLEAR: valid_in = 1'b0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      weight_ff <= weight_in;
      index_ff  <= index_in;
   end

   assign valid  = valid_ff;
   assign weight = weight_ff;
   assign index  = index_ff;

endmodule

@@ src/huffman_code_builder_top.sv @@
// Huffman code builder: loads one symbol word per cycle into a sorted chain of
// cells, merges the two lightest nodes (pop and merge states, n-1 merges), then
// walks the tree and emits one code word per leaf (fetch and visit states per node
// visited, stack and resume states after each leaf other than the last).
// Input is stalled from the final word until the last code word is registered.
// Reset clears control and cell valid bits only; node store and stack are not cleared.
module huffman_code_builder_top #(
   parameter int MAX_SYMBOLS = 16,
   parameter int FREQ_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   hfcb_req_if.sink    req_bus,
   hfcb_rsp_if.source  rsp_bus
);
   import hfcb_pkg::*;

   localparam int NODE_CAP = 2 * MAX_SYMBOLS;
   localparam int IW  = $clog2(NODE_CAP);              // node index
   localparam int WW  = FREQ_BITS + $clog2(MAX_SYMBOLS); // merged weight
   localparam int CW  = $clog2(MAX_SYMBOLS + 1);        // list fill / stack pointer
   localparam int SAW = $clog2(MAX_SYMBOLS);            // stack address
   localparam int NW  = 1 + 2 * IW + SYMBOL_BITS;       // node store word
   localparam int SEW = IW + CODE_BITS + LEN_BITS;      // stack entry
   localparam int FB16 = (FREQ_BITS < FREQ_PORT_BITS) ? FREQ_BITS : FREQ_PORT_BITS;
   localparam logic [FREQ_PORT_BITS-1:0] FMASK = {FREQ_PORT_BITS{1'b1}} >> (FREQ_PORT_BITS - FB16);

   // ---------------- control state
   hfcb_state_type state_ff, state_in;
   logic [CW-1:0]  active_ff, active_in;
   logic [IW-1:0]  node_cnt_ff, node_cnt_in;
   logic [CW-1:0]  sp_ff, sp_in;

   // merge operands
   logic [IW-1:0]  lo_idx_ff, lo_idx_in, hi_idx_ff, hi_idx_in;
   logic [WW-1:0]  lo_w_ff, lo_w_in, hi_w_ff, hi_w_in;

   // tree walk: current node, its code and length
   logic [IW-1:0]        cur_ff, cur_in;
   logic [CODE_BITS-1:0] code_ff, code_in;
   logic [LEN_BITS-1:0]  len_ff, len_in;

   // response word register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SYMBOL_BITS-1:0] rsp_sym_ff, rsp_sym_in;
   logic [CODE_BITS-1:0]   rsp_code_ff, rsp_code_in;
   logic [LEN_BITS-1:0]    rsp_len_ff, rsp_len_in;
   logic                   rsp_last_ff, rsp_last_in;

   // ---------------- cell chain
   hfcb_cell_op_type   cell_op;
   logic [WW-1:0]      ins_weight;
   logic [IW-1:0]      ins_index;
   logic [MAX_SYMBOLS-1:0] cell_ge, cell_valid;
   logic [WW-1:0]      cell_weight [MAX_SYMBOLS];
   logic [IW-1:0]      cell_index  [MAX_SYMBOLS];

   genvar gi;
   generate
      for (gi = 0; gi < MAX_SYMBOLS; gi++) begin : g_cell
         logic          p_ge, p_valid, f_valid;
         logic [WW-1:0] p_weight, f_weight;
         logic [IW-1:0] p_index, f_index;
         if (gi == 0) begin : g_head
            assign p_ge = 1'b0;
            assign p_valid = 1'b0;
            assign p_weight = '0;
            assign p_index = '0;
         end else begin : g_body
            assign p_ge = cell_ge[gi-1];
            assign p_valid = cell_valid[gi-1];
            assign p_weight = cell_weight[gi-1];
            assign p_index = cell_index[gi-1];
         end
         if (gi + 2 < MAX_SYMBOLS) begin : g_far
            assign f_valid = cell_valid[gi+2];
            assign f_weight = cell_weight[gi+2];
            assign f_index = cell_index[gi+2];
         end else begin : g_tail
            assign f_valid = 1'b0;
            assign f_weight = '0;
            assign f_index = '0;
         end
         hfcb_cell #(.WW(WW), .IW(IW)) u_cell (
            .clock(clock), .reset(reset), .op(cell_op),
            .new_weight(ins_weight), .new_index(ins_index),
            .prev_ge(p_ge), .prev_valid(p_valid), .prev_weight(p_weight),
            .prev_index(p_index), .far_valid(f_valid), .far_weight(f_weight),
            .far_index(f_index), .ge(cell_ge[gi]), .valid(cell_valid[gi]),
            .weight(cell_weight[gi]), .index(cell_index[gi])
         );
      end
   endgenerate

   // ---------------- node store and walk stack
   logic [NW-1:0]  node_mem [NODE_CAP];
   logic [NW-1:0]  node_rd_ff;
   logic           node_we;
   logic [IW-1:0]  node_wa;
   logic [NW-1:0]  node_wd;

   logic [SEW-1:0] stack_mem [MAX_SYMBOLS];
   logic [SEW-1:0] stack_rd_ff;
   logic           stack_we;
   logic [SEW-1:0] stack_wd;

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_wa] <= node_wd;
      end
      node_rd_ff <= node_mem[cur_ff];
      if (stack_we) begin
         stack_mem[sp_ff[SAW-1:0]] <= stack_wd;
      end
      stack_rd_ff <= stack_mem[sp_ff[SAW-1:0]];
   end

   // node word: leaf flag, left, right, symbol
   logic                   nd_leaf;
   logic [IW-1:0]          nd_left, nd_right;
   logic [SYMBOL_BITS-1:0] nd_sym;
   assign {nd_leaf, nd_left, nd_right, nd_sym} = node_rd_ff;

   logic                 req_take, can_load, out_free;
   logic [FREQ_PORT_BITS-1:0] freq_masked;
   logic [CW-1:0]        active_after_load;

   assign freq_masked = req_bus.frequency & FMASK;
   assign req_take    = req_bus.valid && (state_ff == ST_LOAD);
   assign can_load    = node_cnt_ff < IW'(MAX_SYMBOLS);
   assign out_free    = !rsp_valid_ff || rsp_bus.ready;
   assign active_after_load = active_ff + CW'(can_load);

   // ---------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_take && req_bus.final_item && (active_after_load != '0)) begin
               state_in = ST_POP;
            end
         end
         ST_POP: state_in = (active_ff > CW'(1)) ? ST_MERGE : ST_FETCH;
         ST_MERGE: state_in = ST_POP;
         ST_FETCH: state_in = ST_VISIT;
         ST_VISIT: begin
            if (!nd_leaf) begin
               state_in = ST_FETCH;
            end else if (out_free) begin
               state_in = (sp_ff == '0) ? ST_LOAD : ST_STACK;
            end
         end
         ST_STACK: state_in = ST_RESUME;
         ST_RESUME: state_in = ST_FETCH;
         default: state_in = ST_LOAD;
      endcase
   end

   // ---------------- outputs and datapath
   always_comb begin
      cell_op     = CELL_HOLD;
      ins_weight  = lo_w_ff + hi_w_ff;
      ins_index   = node_cnt_ff;
      node_we     = 1'b0;
      node_wa     = node_cnt_ff;
      node_wd     = {1'b0, lo_idx_ff, hi_idx_ff, {SYMBOL_BITS{1'b0}}};
      stack_we    = 1'b0;
      stack_wd    = {nd_right, code_ff[CODE_BITS-2:0], 1'b1, len_ff + LEN_BITS'(1)};
      active_in   = active_ff;
      node_cnt_in = node_cnt_ff;
      sp_in       = sp_ff;
      lo_idx_in   = lo_idx_ff;
      hi_idx_in   = hi_idx_ff;
      lo_w_in     = lo_w_ff;
      hi_w_in     = hi_w_ff;
      cur_in      = cur_ff;
      code_in     = code_ff;
      len_in      = len_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_sym_in  = rsp_sym_ff;
      rsp_code_in = rsp_code_ff;
      rsp_len_in  = rsp_len_ff;
      rsp_last_in = rsp_last_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               if (can_load) begin
                  cell_op     = CELL_INSERT;
                  ins_weight  = WW'(freq_masked);
                  node_we     = 1'b1;
                  node_wd     = {1'b1, {IW{1'b0}}, {IW{1'b0}}, req_bus.symbol};
                  active_in   = active_after_load;
                  node_cnt_in = node_cnt_ff + IW'(1);
               end else if (req_bus.final_item && (active_ff == '0)) begin
                  cell_op = CELL_CLEAR;
               end
               if (req_bus.final_item && (active_after_load == '0)) begin
                  active_in   = '0;
                  node_cnt_in = '0;
               end
            end
         end
         ST_POP: begin
            if (active_ff > CW'(1)) begin
               cell_op   = CELL_POP2;
               lo_idx_in = cell_index[0];
               lo_w_in   = cell_weight[0];
               hi_idx_in = cell_index[1];
               hi_w_in   = cell_weight[1];
               active_in = active_ff - CW'(2);
            end else begin
               cur_in  = cell_index[0];
               code_in = '0;
               len_in  = '0;
               sp_in   = '0;
            end
         end
         ST_MERGE: begin
            cell_op     = CELL_INSERT;
            node_we     = 1'b1;
            active_in   = active_ff + CW'(1);
            node_cnt_in = node_cnt_ff + IW'(1);
         end
         ST_VISIT: begin
            if (!nd_leaf) begin
               stack_we = 1'b1;
               sp_in    = sp_ff + CW'(1);
               cur_in   = nd_left;
               code_in  = {code_ff[CODE_BITS-2:0], 1'b0};
               len_in   = len_ff + LEN_BITS'(1);
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sym_in   = nd_sym;
               rsp_code_in  = code_ff;
               rsp_len_in   = len_ff;
               rsp_last_in  = (sp_ff == '0);
               if (sp_ff == '0) begin
                  cell_op     = CELL_CLEAR;
                  active_in   = '0;
                  node_cnt_in = '0;
               end else begin
                  sp_in = sp_ff - CW'(1);
               end
            end
         end
         ST_RESUME: begin
            {cur_in, code_in, len_in} = stack_rd_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         active_ff    <= '0;
         node_cnt_ff  <= '0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         node_cnt_ff  <= node_cnt_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_idx_ff   <= lo_idx_in;
      hi_idx_ff   <= hi_idx_in;
      lo_w_ff     <= lo_w_in;
      hi_w_ff     <= hi_w_in;
      cur_ff      <= cur_in;
      code_ff     <= code_in;
      len_ff      <= len_in;
      rsp_sym_ff  <= rsp_sym_in;
      rsp_code_ff <= rsp_code_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_last_ff <= rsp_last_in;
   end

   // ---------------- ports
   assign req_bus.ready       = (state_ff == ST_LOAD);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.leaf_symbol = rsp_sym_ff;
   assign rsp_bus.code_bits   = rsp_code_ff;
   assign rsp_bus.code_length = rsp_len_ff;
   assign rsp_bus.last_code   = rsp_last_ff;

   // ---------------- checks
   `include "huffman_code_builder_top_assert.svh"

   // fill count tracks the occupied cells
   `HFCB_ASSERT_ALWAYS(a_fill_matches, clock, reset, $countones(cell_valid) == active_ff)
   // occupied cells form an unbroken run from the head
   `HFCB_ASSERT_ALWAYS(a_cells_packed, clock, reset, (cell_valid & (cell_valid + MAX_SYMBOLS'(1))) == '0)
   // a merge never overfills the list
   `HFCB_ASSERT_NEXT(a_merge_room, clock, reset, state_ff == ST_MERGE, active_ff != '0 && active_ff <= CW'(MAX_SYMBOLS))

endmodule
